FILE: src/bcm_pkg.sv
// ----------------------------------------------------------------------------
// bcm_pkg
// Field widths, stage codes, result layout and sequencer types shared by the
// breath cycle monitor, its channels and its serial divider.
// ----------------------------------------------------------------------------
package bcm_pkg;

    localparam int STAGE_W = 3;
    localparam int FLOW_W  = 16;
    localparam int TICK_W  = 7;
    localparam int BPM_W   = 16;
    localparam int RATIO_W = 8;
    localparam int LEAK_W  = 16;
    localparam int VOL_W   = 32;
    localparam int MS_W    = 20;

    localparam logic [STAGE_W-1:0] STG_IDLE       = 3'd0;
    localparam logic [STAGE_W-1:0] STG_ERROR      = 3'd1;
    localparam logic [STAGE_W-1:0] STG_INSP_START = 3'd2;
    localparam logic [STAGE_W-1:0] STG_INSP_END   = 3'd3;
    localparam logic [STAGE_W-1:0] STG_EXP_START  = 3'd4;
    localparam logic [STAGE_W-1:0] STG_EXP_END    = 3'd5;

    localparam logic [TICK_W-1:0]  TICK_RESET   = 7'd10;
    localparam int                 BPM_DVD_W    = 20;
    localparam logic [BPM_DVD_W-1:0] BPM_DIVIDEND = 20'd600000;
    localparam logic [BPM_W-1:0]   BPM_MAX      = 16'd60000;
    localparam logic [RATIO_W-1:0] RATIO_UNIT   = 8'd10;
    localparam logic [RATIO_W-1:0] RATIO_MAX    = 8'd255;
    localparam logic [LEAK_W-1:0]  LEAK_POS_MAX = 16'h7FFF;
    localparam logic [LEAK_W-1:0]  LEAK_NEG_MAX = 16'h8000;
    localparam logic [MS_W-1:0]    MS_MAX       = 20'hFFFFF;
    localparam int                 VOL_DIV      = 60;
    localparam int                 MV_DIV       = 10000;
    localparam int                 MV_DVD_W     = 48;

    // corrected sums are held in 64 bits; the divider sees them times tick_ms
    localparam int CORR_W    = 64;
    localparam int DIV_DVD_W = CORR_W + TICK_W;
    localparam int DIV_CNT_W = 7;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PRE1  = 6'b000010,
        S_PRE2  = 6'b000100,
        S_SETUP = 6'b001000,
        S_DIV   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    typedef enum logic [3:0] {
        OP_BPM = 4'd0,
        OP_RAT = 4'd1,
        OP_TK  = 4'd2,
        OP_TKI = 4'd3,
        OP_TKE = 4'd4,
        OP_LM  = 4'd5,
        OP_VI  = 4'd6,
        OP_VE  = 4'd7,
        OP_MV  = 4'd8
    } t_op;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] count;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    typedef struct packed {
        logic [BPM_W-1:0]          breaths_per_min_x10;
        logic [RATIO_W-1:0]        ratio_insp_x10;
        logic [RATIO_W-1:0]        ratio_exp_x10;
        logic signed [LEAK_W-1:0]  leak_avg;
        logic [VOL_W-1:0]          insp_volume;
        logic [VOL_W-1:0]          exp_volume;
        logic [VOL_W-1:0]          minute_volume;
        logic [MS_W-1:0]           insp_ms;
        logic [MS_W-1:0]           exp_ms;
    } t_result;

endpackage

FILE: src/bcm_if.sv
// ----------------------------------------------------------------------------
// bcm channels
// Valid/ready channels of the breath cycle monitor: tick input, result output
// and the tick_ms configuration write.
// ----------------------------------------------------------------------------
interface bcm_in_if import bcm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [STAGE_W-1:0]        stage;
    logic signed [FLOW_W-1:0]  flow;

    modport source (output valid, output stage, output flow, input ready);
    modport sink   (input valid, input stage, input flow, output ready);
endinterface

interface bcm_out_if import bcm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [BPM_W-1:0]          breaths_per_min_x10;
    logic [RATIO_W-1:0]        ratio_insp_x10;
    logic [RATIO_W-1:0]        ratio_exp_x10;
    logic signed [LEAK_W-1:0]  leak_avg;
    logic [VOL_W-1:0]          insp_volume;
    logic [VOL_W-1:0]          exp_volume;
    logic [VOL_W-1:0]          minute_volume;
    logic [MS_W-1:0]           insp_ms;
    logic [MS_W-1:0]           exp_ms;

    modport source (output valid, output breaths_per_min_x10, output ratio_insp_x10,
                    output ratio_exp_x10, output leak_avg, output insp_volume,
                    output exp_volume, output minute_volume, output insp_ms,
                    output exp_ms, input ready);
    modport sink   (input valid, input breaths_per_min_x10, input ratio_insp_x10,
                    input ratio_exp_x10, input leak_avg, input insp_volume,
                    input exp_volume, input minute_volume, input insp_ms,
                    input exp_ms, output ready);
endinterface

interface bcm_cfg_if import bcm_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [TICK_W-1:0]  tick_ms;

    modport source (output valid, output tick_ms, input ready);
    modport sink   (input valid, input tick_ms, output ready);
endinterface

FILE: src/bcm_div.sv
// ----------------------------------------------------------------------------
// bcm_div
// Unsigned restoring divider, one quotient bit per cycle. The dividend comes
// in left aligned; after count shifts the quotient sits in the low bits.
// ----------------------------------------------------------------------------
module bcm_div import bcm_pkg::*; #(
    parameter int DSW = 21
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_div_ctl             i_ctl,
    input  logic [DIV_DVD_W-1:0] i_dividend,
    input  logic [DSW-1:0]       i_divisor,
    output t_div_sts             o_sts,
    output logic [DIV_DVD_W-1:0] o_quotient
);

    logic [DIV_DVD_W-1:0] r_quo;
    logic [DSW-1:0]       r_rem;
    logic [DSW-1:0]       r_dsr;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DSW:0]   w_sh;
    logic [DSW:0]   w_diff;
    logic           w_ge;
    logic [DSW-1:0] w_rem_nx;

    assign w_sh     = {r_rem, r_quo[DIV_DVD_W-1]};
    assign w_ge     = w_sh >= {1'b0, r_dsr};
    assign w_diff   = w_sh - {1'b0, r_dsr};
    assign w_rem_nx = w_ge ? w_diff[DSW-1:0] : w_sh[DSW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_DVD_W-2:0], w_ge};
            r_rem <= w_rem_nx;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

FILE: src/breath_cycle_monitor.sv
// ----------------------------------------------------------------------------
// breath_cycle_monitor
// Breath-by-breath ventilation statistics from staged flow ticks.
// ----------------------------------------------------------------------------
// Ticks that do not close a breath are taken one per cycle. A tick with
// inspiration start right after expiration end closes the breath: its sums are
// frozen and the tick itself starts the new breath. The result is then worked
// out by one shared bit-serial divider running nine divisions in turn (rate,
// ratio, three tick counts, mean leak, two volumes, minute volume); no tick is
// taken while they run. A finished result waits in the output register, so
// the next ticks are taken while it is still pending.
module breath_cycle_monitor import bcm_pkg::*; #(
    parameter int TIME_BITS = 20,
    parameter int SUM_BITS  = 40
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcm_cfg_if.sink     i_cfg,
    bcm_in_if.sink      i_in,
    bcm_out_if.source   o_out
);

    localparam int TB  = TIME_BITS;
    localparam int SB  = SUM_BITS;
    localparam int DSW = TB + 1;
    localparam int MA  = VOL_W + 1;
    localparam int MB  = TB + 1;
    localparam int PW  = MA + MB;
    localparam int AW  = CORR_W + 2;
    localparam int DVW = DIV_DVD_W;

    function automatic logic [TB-1:0] f_time_add(input logic [TB-1:0] acc,
                                                 input logic [TICK_W-1:0] tick);
        logic [TB:0] s;
        s = {1'b0, acc} + (TB+1)'(tick);
        return s[TB] ? {TB{1'b1}} : s[TB-1:0];
    endfunction

    function automatic logic signed [SB-1:0] f_sum_add(input logic signed [SB-1:0] acc,
                                                       input logic signed [FLOW_W-1:0] v);
        logic signed [SB:0] s;
        s = (SB+1)'(acc) + (SB+1)'(v);
        if (s[SB] != s[SB-1]) begin
            return s[SB] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};
        end
        return s[SB-1:0];
    endfunction

    function automatic logic [VOL_W-1:0] f_sat32(input logic [DVW-1:0] q);
        return (|q[DVW-1:VOL_W]) ? {VOL_W{1'b1}} : q[VOL_W-1:0];
    endfunction

    // tick accumulation
    logic [TICK_W-1:0]       r_tick;
    logic [STAGE_W-1:0]      r_prev;
    logic [TB-1:0]           r_acc_ti;
    logic [TB-1:0]           r_acc_te;
    logic signed [SB-1:0]    r_acc_leak;
    logic signed [SB-1:0]    r_acc_isum;
    logic signed [SB-1:0]    r_acc_esum;

    // frozen breath and partial results
    t_state                  r_state;
    t_state                  n_state;
    t_op                     r_op;
    t_op                     n_op;
    logic [TB-1:0]           r_ti;
    logic [TB-1:0]           r_te;
    logic [TB:0]             r_t;
    logic signed [SB-1:0]    r_leak;
    logic signed [SB-1:0]    r_isum;
    logic signed [SB-1:0]    r_esum;
    logic [BPM_W-1:0]        r_bpm;
    logic [RATIO_W-1:0]      r_ri;
    logic [RATIO_W-1:0]      r_re;
    logic signed [LEAK_W-1:0] r_lm;
    logic [TB:0]             r_tk;
    logic [TB-1:0]           r_tki;
    logic [TB-1:0]           r_tke;
    logic [VOL_W-1:0]        r_vi;
    logic [VOL_W-1:0]        r_ve;
    logic [VOL_W-1:0]        r_mv;
    logic signed [PW-1:0]    r_prod;
    logic [CORR_W-1:0]       r_m;
    logic                    r_zero;
    t_result                 r_out;
    logic                    r_out_valid;

    logic                    w_in_acc;
    logic                    w_end;
    logic                    w_out_free;
    logic signed [MA-1:0]    w_mul_a;
    logic signed [MB-1:0]    w_mul_b;
    logic signed [PW-1:0]    w_prod;
    logic signed [SB-1:0]    w_sum_sel;
    logic signed [AW-1:0]    w_diff;
    logic signed [CORR_W-1:0] w_corr;
    logic [CORR_W-1:0]       w_mag;
    logic                    w_zero;
    logic                    w_i_le_e;
    logic [TB-1:0]           w_big;
    logic [TB-1:0]           w_sml;
    logic [TB+3:0]           w_num10;
    logic [SB-1:0]           w_leak_mag;
    logic [DVW-1:0]          w_vdvd;
    logic [DVW-1:0]          w_dvd;
    logic [DSW-1:0]          w_dsr;
    logic [DIV_CNT_W-1:0]    w_cnt;
    t_div_ctl                w_div_ctl;
    t_div_sts                w_div_sts;
    logic [DVW-1:0]          w_q;
    logic [BPM_W-1:0]        w_bpm;
    logic [RATIO_W-1:0]      w_rsat;
    logic [LEAK_W-1:0]       w_lm;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = (r_state == S_IDLE);
    assign w_in_acc    = i_in.valid && i_in.ready;
    assign w_end       = (i_in.stage == STG_INSP_START) && (r_prev == STG_EXP_END);
    assign w_out_free  = !r_out_valid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick <= TICK_RESET;
        end else if (i_cfg.valid) begin
            r_tick <= i_cfg.tick_ms;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev     <= STG_IDLE;
            r_acc_ti   <= '0;
            r_acc_te   <= '0;
            r_acc_leak <= '0;
            r_acc_isum <= '0;
            r_acc_esum <= '0;
        end else if (w_in_acc) begin
            r_prev <= i_in.stage;
            unique case (i_in.stage)
                STG_IDLE, STG_ERROR: begin
                    r_acc_ti   <= '0;
                    r_acc_te   <= '0;
                    r_acc_leak <= '0;
                    r_acc_isum <= '0;
                    r_acc_esum <= '0;
                end
                STG_INSP_START, STG_INSP_END: begin
                    if (w_end) begin
                        // restart the sums with this tick
                        r_acc_ti   <= f_time_add('0, r_tick);
                        r_acc_te   <= '0;
                        r_acc_leak <= f_sum_add('0, i_in.flow);
                        r_acc_isum <= f_sum_add('0, i_in.flow);
                        r_acc_esum <= '0;
                    end else begin
                        r_acc_ti   <= f_time_add(r_acc_ti, r_tick);
                        r_acc_leak <= f_sum_add(r_acc_leak, i_in.flow);
                        r_acc_isum <= f_sum_add(r_acc_isum, i_in.flow);
                    end
                end
                STG_EXP_START, STG_EXP_END: begin
                    r_acc_te   <= f_time_add(r_acc_te, r_tick);
                    r_acc_leak <= f_sum_add(r_acc_leak, i_in.flow);
                    r_acc_esum <= f_sum_add(r_acc_esum, i_in.flow);
                end
                default: begin
                end
            endcase
        end
    end

    // shared multiplier: leak times tick count, or volume times rate
    always_comb begin
        if (r_op == OP_MV) begin
            w_mul_a = $signed({1'b0, r_vi});
            w_mul_b = $signed({1'b0, TB'(r_bpm)});
        end else begin
            w_mul_a = MA'(r_lm);
            w_mul_b = $signed({1'b0, (r_op == OP_VE) ? r_tke : r_tki});
        end
    end
    assign w_prod = w_mul_a * w_mul_b;

    assign w_sum_sel = (r_op == OP_VE) ? r_esum : r_isum;
    assign w_diff    = AW'(w_sum_sel) - AW'(r_prod);

    always_comb begin
        if ((&w_diff[AW-1:CORR_W-1]) || !(|w_diff[AW-1:CORR_W-1])) begin
            w_corr = w_diff[CORR_W-1:0];
        end else begin
            w_corr = w_diff[AW-1] ? {1'b1, {(CORR_W-1){1'b0}}} : {1'b0, {(CORR_W-1){1'b1}}};
        end
    end
    assign w_mag  = w_corr[CORR_W-1] ? CORR_W'(-w_corr) : CORR_W'(w_corr);
    assign w_zero = w_corr[CORR_W-1] || (w_corr == '0);

    assign w_i_le_e   = r_ti <= r_te;
    assign w_big      = w_i_le_e ? r_te : r_ti;
    assign w_sml      = w_i_le_e ? r_ti : r_te;
    assign w_num10    = (TB+4)'({w_big, 3'b000}) + (TB+4)'({w_big, 1'b0});
    assign w_leak_mag = r_leak[SB-1] ? SB'(-r_leak) : SB'(r_leak);
    assign w_vdvd     = DVW'(r_m) * DVW'(r_tick);

    // left-align each dividend so the quotient lands in the low bits
    always_comb begin
        w_dvd = '0;
        w_dsr = '0;
        w_cnt = '0;
        unique case (r_op)
            OP_BPM: begin
                w_dvd = DVW'(BPM_DIVIDEND) << (DVW - BPM_DVD_W);
                w_dsr = r_t;
                w_cnt = DIV_CNT_W'(BPM_DVD_W);
            end
            OP_RAT: begin
                w_dvd = DVW'(w_num10) << (DVW - TB - 4);
                w_dsr = DSW'(w_sml);
                w_cnt = DIV_CNT_W'(TB + 4);
            end
            OP_TK: begin
                w_dvd = DVW'(r_t) << (DVW - TB - 1);
                w_dsr = DSW'(r_tick);
                w_cnt = DIV_CNT_W'(TB + 1);
            end
            OP_TKI: begin
                w_dvd = DVW'(r_ti) << (DVW - TB);
                w_dsr = DSW'(r_tick);
                w_cnt = DIV_CNT_W'(TB);
            end
            OP_TKE: begin
                w_dvd = DVW'(r_te) << (DVW - TB);
                w_dsr = DSW'(r_tick);
                w_cnt = DIV_CNT_W'(TB);
            end
            OP_LM: begin
                w_dvd = DVW'(w_leak_mag) << (DVW - SB);
                w_dsr = r_tk;
                w_cnt = DIV_CNT_W'(SB);
            end
            OP_VI, OP_VE: begin
                w_dvd = w_vdvd;
                w_dsr = DSW'(VOL_DIV);
                w_cnt = DIV_CNT_W'(DVW);
            end
            OP_MV: begin
                w_dvd = DVW'(r_prod[MV_DVD_W-1:0]) << (DVW - MV_DVD_W);
                w_dsr = DSW'(MV_DIV);
                w_cnt = DIV_CNT_W'(MV_DVD_W);
            end
            default: begin
            end
        endcase
    end

    assign w_div_ctl.start = (r_state == S_SETUP);
    assign w_div_ctl.count = w_cnt;

    bcm_div #(
        .DSW (DSW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (w_div_ctl),
        .i_dividend (w_dvd),
        .i_divisor  (w_dsr),
        .o_sts      (w_div_sts),
        .o_quotient (w_q)
    );

    assign w_bpm  = ((r_t == '0) || (w_q > DVW'(BPM_MAX))) ? BPM_MAX : w_q[BPM_W-1:0];
    assign w_rsat = ((w_sml == '0) || (w_q > DVW'(RATIO_MAX))) ? RATIO_MAX
                                                                : w_q[RATIO_W-1:0];

    always_comb begin
        if (r_tk == '0) begin
            if (r_leak[SB-1]) begin
                w_lm = LEAK_NEG_MAX;
            end else if (|r_leak) begin
                w_lm = LEAK_POS_MAX;
            end else begin
                w_lm = '0;
            end
        end else if (r_leak[SB-1]) begin
            w_lm = (w_q > DVW'(LEAK_NEG_MAX)) ? LEAK_NEG_MAX : LEAK_W'(-w_q[LEAK_W-1:0]);
        end else begin
            w_lm = (w_q > DVW'(LEAK_POS_MAX)) ? LEAK_POS_MAX : w_q[LEAK_W-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_op    = r_op;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc && w_end) begin
                    n_state = S_PRE1;
                    n_op    = OP_BPM;
                end
            end
            S_PRE1:  n_state = S_PRE2;
            S_PRE2:  n_state = S_SETUP;
            S_SETUP: n_state = S_DIV;
            S_DIV: begin
                if (w_div_sts.done) begin
                    if (r_op == OP_MV) begin
                        n_state = S_DONE;
                    end else begin
                        n_op    = t_op'(r_op + 1'b1);
                        n_state = S_PRE1;
                    end
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op    <= OP_BPM;
        end else begin
            r_state <= n_state;
            r_op    <= n_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc && w_end) begin
            r_ti   <= r_acc_ti;
            r_te   <= r_acc_te;
            r_t    <= {1'b0, r_acc_ti} + {1'b0, r_acc_te};
            r_leak <= r_acc_leak;
            r_isum <= r_acc_isum;
            r_esum <= r_acc_esum;
        end
        if (r_state == S_PRE1) begin
            r_prod <= w_prod;
        end
        if (r_state == S_PRE2) begin
            r_m    <= w_mag;
            r_zero <= w_zero;
        end
        if ((r_state == S_DIV) && w_div_sts.done) begin
            unique case (r_op)
                OP_BPM: r_bpm <= w_bpm;
                OP_RAT: begin
                    r_ri <= w_i_le_e ? RATIO_UNIT : w_rsat;
                    r_re <= w_i_le_e ? w_rsat : RATIO_UNIT;
                end
                OP_TK:  r_tk  <= (r_tick == '0) ? '0 : w_q[TB:0];
                OP_TKI: r_tki <= (r_tick == '0) ? '0 : w_q[TB-1:0];
                OP_TKE: r_tke <= (r_tick == '0) ? '0 : w_q[TB-1:0];
                OP_LM:  r_lm  <= w_lm;
                OP_VI:  r_vi  <= r_zero ? '0 : f_sat32(w_q);
                OP_VE:  r_ve  <= f_sat32(w_q);
                OP_MV:  r_mv  <= f_sat32(w_q);
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            priority if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_DONE) && w_out_free) begin
            r_out.breaths_per_min_x10 <= r_bpm;
            r_out.ratio_insp_x10      <= r_ri;
            r_out.ratio_exp_x10       <= r_re;
            r_out.leak_avg            <= r_lm;
            r_out.insp_volume         <= r_vi;
            r_out.exp_volume          <= r_ve;
            r_out.minute_volume       <= r_mv;
            r_out.insp_ms <= (33'(r_ti) > 33'(MS_MAX)) ? MS_MAX : MS_W'(r_ti);
            r_out.exp_ms  <= (33'(r_te) > 33'(MS_MAX)) ? MS_MAX : MS_W'(r_te);
        end
    end

    assign o_out.valid               = r_out_valid;
    assign o_out.breaths_per_min_x10 = r_out.breaths_per_min_x10;
    assign o_out.ratio_insp_x10      = r_out.ratio_insp_x10;
    assign o_out.ratio_exp_x10       = r_out.ratio_exp_x10;
    assign o_out.leak_avg            = r_out.leak_avg;
    assign o_out.insp_volume         = r_out.insp_volume;
    assign o_out.exp_volume          = r_out.exp_volume;
    assign o_out.minute_volume       = r_out.minute_volume;
    assign o_out.insp_ms             = r_out.insp_ms;
    assign o_out.exp_ms              = r_out.exp_ms;

`ifndef ASSERT_OFF
    a_div_free_at_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SETUP) |-> !w_div_sts.busy)
        else $error("divider started while still busy");

    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_sts.done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide step");

    a_load_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded without a finished breath");

    a_ratio_unit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.ratio_insp_x10 == RATIO_UNIT ||
                         r_out.ratio_exp_x10 == RATIO_UNIT))
        else $error("neither ratio side is unity");

    a_bpm_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.breaths_per_min_x10 <= BPM_MAX))
        else $error("breath rate above saturation");
`endif

endmodule
